FILE: sv/dacc_pkg.sv
// ----------------------------------------------------------------------------
// Decimal accumulator package
// Shared types, opcodes and flow codes for the decimal accumulator block.
// ----------------------------------------------------------------------------
`default_nettype none
package dacc_pkg;
  localparam int WordW = 20;
  localparam int DataW = 32;

  typedef enum logic [6:0] {
    OP_READ = 7'd10, OP_WRITE = 7'd11, OP_LOAD = 7'd20, OP_STORE = 7'd21,
    OP_ADD = 7'd30, OP_SUBTRACT = 7'd31, OP_DIVIDE = 7'd32, OP_MULTIPLY = 7'd33,
    OP_BRANCH = 7'd40, OP_BRANCHNEG = 7'd41, OP_BRANCHZERO = 7'd42, OP_HALT = 7'd43
  } opcode_t;

  typedef enum logic [1:0] {
    FLOW_SEQ = 2'd0, FLOW_BRANCH = 2'd1, FLOW_HALT = 2'd2
  } flow_t;

  typedef struct packed {
    logic [1:0]        flow;
    logic [13:0]       branch_target;
    logic              report_valid;
    logic [6:0]        report_address;
    logic signed [31:0] report_value;
    logic              divide_by_zero;
    logic signed [31:0] accumulator_value;
  } result_t;
endpackage
`default_nettype wire

FILE: sv/dacc_if.sv
// ----------------------------------------------------------------------------
// Decimal accumulator channel interfaces
// Valid/ready channels for instruction words and execution results.
// ----------------------------------------------------------------------------
`default_nettype none
interface dacc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] instruction_word;
  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

interface dacc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         flow;
  logic [13:0]        branch_target;
  logic               report_valid;
  logic [6:0]         report_address;
  logic signed [31:0] report_value;
  logic               divide_by_zero;
  logic signed [31:0] accumulator_value;
  modport source (output valid, output flow, output branch_target, output report_valid,
    output report_address, output report_value, output divide_by_zero,
    output accumulator_value, input ready);
  modport sink (input valid, input flow, input branch_target, input report_valid,
    input report_address, input report_value, input divide_by_zero,
    input accumulator_value, output ready);
endinterface
`default_nettype wire

FILE: sv/dacc_divider.sv
// ----------------------------------------------------------------------------
// Decimal accumulator divider
// Iterative unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module dacc_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && count == 6'd31;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
        count <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        count <= count + 6'd1;
        if (count == 6'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/decimal_accumulator_cpu_execute_top.sv
// ----------------------------------------------------------------------------
// Decimal accumulator execute unit
// Executes one decimal instruction word against 100 cells and an accumulator.
// ----------------------------------------------------------------------------
// An instruction word enters on the in channel; one result leaves on the out
// channel for every word. The word is split into opcode, address and
// immediate in four steps by reciprocal multiplication, then the cell memory
// is read with a registered port and the operation runs under a small
// sequencer. After the read and wait states the operation executes; MULTIPLY
// adds a multiply state and DIVIDE waits on the one-bit-per-cycle divider
// and a sign-fix state before the result is offered. Once the result is
// transferred the unit returns to idle and accepts the next word.
// The unit accepts no new word until the result has been transferred, so a
// stalled receiver holds the result and the unit in place.
// After reset a clearing pass writes zero to all 100 cells, one a cycle, and
// no word is accepted until the pass ends. The accumulator resets to zero.
// ----------------------------------------------------------------------------
`default_nettype none
module decimal_accumulator_cpu_execute_top #(
  parameter int CELL_COUNT = 100
) (
  input wire logic    clk,
  input wire logic    rst,
  dacc_in_if.sink     in_ch,
  dacc_out_if.source  out_ch
);
  import dacc_pkg::*;

  localparam int AddrW = $clog2(CELL_COUNT);
  localparam logic [40:0] OpRecip = 41'd1717987;
  localparam logic [33:0] AdrRecip = 34'd10486;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIGIT, S_READ, S_WAIT, S_EXEC, S_MUL, S_DIV, S_DIVFIX, S_OUT
  } state_t;

  state_t state;
  logic [DataW-1:0] mem [CELL_COUNT];
  logic [DataW-1:0] cell_q;
  logic [DataW-1:0] cell_val;
  logic [AddrW-1:0] clr_addr;
  logic [19:0] rest;
  logic [6:0]  opcode;
  logic [6:0]  addr;
  logic [6:0]  imm;
  logic [1:0]  dstep;
  logic [40:0] op_prod;
  logic [33:0] adr_prod;
  logic [31:0] acc;
  logic [31:0] prod;
  logic        zero_word;
  logic        addr_ok;
  logic        div_start;
  logic        div_done;
  logic [31:0] quotient;
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic        div_neg;
  result_t     res;
  result_t     exec_res;
  logic [31:0] exec_acc;
  logic        exec_mul;
  logic        exec_div;

  assign addr_ok = addr < 7'(CELL_COUNT);
  assign cell_val = addr_ok ? cell_q : '0;
  assign mag_a = acc[31] ? 32'(0 - acc) : acc;
  assign mag_b = cell_q[31] ? 32'(0 - cell_q) : cell_q;
  assign op_prod = 41'(rest) * OpRecip;
  assign adr_prod = 34'(rest) * AdrRecip;

  dacc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mag_a), .divisor(mag_b),
    .done(div_done), .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      mem[clr_addr] <= '0;
    end else if (state == S_EXEC && !zero_word && addr_ok) begin
      if (opcode == OP_READ) begin
        mem[addr[AddrW-1:0]] <= 32'(imm);
      end else if (opcode == OP_STORE) begin
        mem[addr[AddrW-1:0]] <= acc;
      end
    end
    cell_q <= mem[addr[AddrW-1:0]];
  end

  always_comb begin
    exec_res = '0;
    exec_acc = acc;
    exec_mul = 1'b0;
    exec_div = 1'b0;
    if (zero_word) begin
      exec_res.flow = FLOW_HALT;
    end else begin
      case (opcode)
        OP_WRITE: begin
          exec_res.report_valid = 1'b1;
          exec_res.report_address = addr;
          exec_res.report_value = cell_val;
        end
        OP_LOAD: exec_acc = cell_val;
        OP_ADD: exec_acc = acc + cell_val;
        OP_SUBTRACT: exec_acc = acc - cell_val;
        OP_MULTIPLY: exec_mul = 1'b1;
        OP_DIVIDE: begin
          if (cell_val == '0) begin
            exec_res.divide_by_zero = 1'b1;
          end else begin
            exec_div = 1'b1;
          end
        end
        OP_BRANCH: begin
          exec_res.flow = FLOW_BRANCH;
          exec_res.branch_target = 14'(addr) * 14'd100 + 14'(imm);
        end
        OP_BRANCHNEG: begin
          if (acc[31] && imm != '0) begin
            exec_res.flow = FLOW_BRANCH;
            exec_res.branch_target = 14'(imm);
          end
        end
        OP_BRANCHZERO: begin
          if (acc == '0 && imm != '0) begin
            exec_res.flow = FLOW_BRANCH;
            exec_res.branch_target = 14'(imm);
          end
        end
        OP_HALT: exec_res.flow = FLOW_HALT;
        default: ;
      endcase
    end
    exec_res.accumulator_value = exec_acc;
  end

  always_ff @(posedge clk) begin
    div_start <= !rst && state == S_EXEC && exec_div;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      acc <= '0;
      in_ch.ready <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AddrW'(CELL_COUNT - 1)) begin
            state <= S_IDLE;
            in_ch.ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            in_ch.ready <= 1'b0;
            rest <= in_ch.instruction_word;
            zero_word <= in_ch.instruction_word == '0;
            opcode <= '0;
            addr <= '0;
            dstep <= '0;
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          dstep <= dstep + 2'd1;
          case (dstep)
            2'd0: opcode <= op_prod[40:34];
            2'd1: rest <= rest - 20'(opcode) * 20'd10000;
            2'd2: addr <= adr_prod[26:20];
            default: begin
              imm <= 7'(rest - 20'(addr) * 20'd100);
              state <= S_READ;
            end
          endcase
        end
        S_READ: state <= S_WAIT;
        S_WAIT: state <= S_EXEC;
        S_EXEC: begin
          acc <= exec_acc;
          res <= exec_res;
          if (exec_mul) begin
            prod <= acc * cell_val;
            state <= S_MUL;
          end else if (exec_div) begin
            div_neg <= acc[31] ^ cell_val[31];
            state <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_MUL: begin
          acc <= prod;
          res.accumulator_value <= prod;
          state <= S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DIVFIX;
          end
        end
        S_DIVFIX: begin
          acc <= div_neg ? 32'(0 - quotient) : quotient;
          res.accumulator_value <= div_neg ? 32'(0 - quotient) : quotient;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            in_ch.ready <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.flow = res.flow;
  assign out_ch.branch_target = res.branch_target;
  assign out_ch.report_valid = res.report_valid;
  assign out_ch.report_address = res.report_address;
  assign out_ch.report_value = res.report_value;
  assign out_ch.divide_by_zero = res.divide_by_zero;
  assign out_ch.accumulator_value = res.accumulator_value;
endmodule
`default_nettype wire

FILE: sv/dacc_checker.sv
// ----------------------------------------------------------------------------
// Decimal accumulator port checker
// Checks the port behavior of the execute unit over time.
// ----------------------------------------------------------------------------
`default_nettype none
module dacc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] flow,
  input wire logic report_valid,
  input wire logic divide_by_zero
);
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> flow != 2'd3) else $error("bad flow code");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(report_valid && divide_by_zero)) else $error("two events");
endmodule

bind decimal_accumulator_cpu_execute_top dacc_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .flow(out_ch.flow), .report_valid(out_ch.report_valid),
  .divide_by_zero(out_ch.divide_by_zero)
);
`default_nettype wire
